// File: hw/rtl/hsasd_pkg.sv
`timescale 1ns / 1ps
package hsasd_pkg;

   // parameter defaults and limits of the internal angle and period widths
   localparam int ANGLE_BITS_DEF  = 16;
   localparam int PERIOD_BITS_DEF = 16;
   localparam int ANGLE_MAX_W     = 24;
   localparam int PERIOD_MAX_W    = 32;

   // stream fields
   localparam int CODE_W      = 3;
   localparam int PERIOD_FW   = 16;
   localparam int LOOP_FW     = 16;
   localparam int ANGLE_FW    = 16;
   localparam int DIR_W       = 2;
   localparam int SPEED_W     = 40;
   localparam int RPM_W       = 25;
   localparam int CORR_W      = 19;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 128;

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 40;
   localparam int PHASE_W     = 16;
   localparam int SPEED_NUM_W = 40;
   localparam int RPM_NUM_W   = 32;
   localparam int ALPHA_W     = 17;
   localparam int CDIV_W      = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PHASE_OFFSET       = 3'd0,
      CSR_SPEED_NUMERATOR    = 3'd1,
      CSR_RPM_NUMERATOR      = 3'd2,
      CSR_FILTER_ALPHA       = 3'd3,
      CSR_CORRECTION_DIVISOR = 3'd4
   } csr_addr_type;

   localparam logic [PHASE_W-1:0]     PHASE_RST = 16'd0;
   localparam logic [SPEED_NUM_W-1:0] SPEED_NUM_RST = 40'd229064922453;
   localparam logic [RPM_NUM_W-1:0]   RPM_NUM_RST = 32'd16000000;
   localparam logic [ALPHA_W-1:0]     ALPHA_RST = 17'd15591;
   localparam logic [CDIV_W-1:0]      CDIV_RST = 16'd10000;
   localparam logic [ALPHA_W-1:0]     ALPHA_ONE = 17'd65536;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 40'h7F_FFFF_FFFF;
   localparam logic [SPEED_W-1:0] RPM_MAX   = 40'h00_00FF_FFFF;
   localparam logic [SPEED_W-1:0] CORR_MAX  = 40'd214749;

   // shared serial divider
   localparam int DIV_DVD_W = 40;
   localparam int DIV_DSR_W = 32;
   localparam int DIV_STEPS = 40;
   localparam int DIV_CNT_W = 6;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] NO_SECTOR = 3'd6;

   typedef enum logic [0:0] {
      OP_STARTUP = 1'b0,
      OP_EDGE    = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SPD_GO,
      BK_SPD_WAIT,
      BK_RPM_GO,
      BK_RPM_WAIT,
      BK_FLT_MUL0,
      BK_FLT_MUL1,
      BK_FLT_SUM,
      BK_COR_GO,
      BK_COR_WAIT,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [SPEED_NUM_W-1:0] speed_num;
      logic [RPM_NUM_W-1:0]   rpm_num;
      logic [ALPHA_W-1:0]     alpha;
      logic [CDIV_W-1:0]      corr_div;
   } back_cfg_type;

   typedef struct packed {
      op_type                  op;
      logic                    period_zero;
      logic [PERIOD_MAX_W-1:0] period;
      logic signed [DIR_W-1:0] dir;
      logic [ANGLE_FW-1:0]     angle;
      logic                    err_neg;
      logic [ANGLE_MAX_W-1:0]  err_mag;
   } item_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_DVD_W-1:0] dividend;
      logic [DIV_DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_DVD_W-1:0] quotient;
   } div_rsp_type;

   // sector order 5,4,6,2,3,1 gives index 0 to 5, invalid codes give no sector
   function automatic logic [2:0] sector_index(input logic [CODE_W-1:0] code);
      logic [2:0] idx;
      unique case (code)
         3'd1:    idx = 3'd5;
         3'd2:    idx = 3'd3;
         3'd3:    idx = 3'd4;
         3'd4:    idx = 3'd1;
         3'd5:    idx = 3'd0;
         3'd6:    idx = 3'd2;
         default: idx = NO_SECTOR;
      endcase
      return idx;
   endfunction

   // n twelfths of a turn, rounded half up; small table over n in 0..12
   function automatic logic [ANGLE_MAX_W:0] twelfths(input logic [3:0] n, input int ab);
      logic [47:0] t;
      t = ({44'd0, n} << ab) + 48'd6;
      t = t / 48'd12;
      return t[ANGLE_MAX_W:0];
   endfunction

endpackage

// File: hw/rtl/hall_sector_angle_speed_decoder_top.sv
`timescale 1ns / 1ps
// Hall sector decoder: each request carries a hall code, an edge capture period and the
// control loop angle, and gives one response with the hall angle, direction, signed speed
// per control period, raw and filtered electrical rpm and an angle correction. A startup
// request goes from the queue through the idle state to the done state and the output
// register. An edge request runs three passes of the shared 40-step serial divider (speed,
// rpm, correction), each with a start and a wait state, plus the two filter multiply
// states and the filter sum state; with a zero period only the correction pass runs. The
// front end and a two-entry queue take further requests while the queue has room, as the
// back end works and a response waits. Configuration writes belong to idle periods.
module hall_sector_angle_speed_decoder_top #(
   parameter int ANGLE_BITS  = hsasd_pkg::ANGLE_BITS_DEF,
   parameter int PERIOD_BITS = hsasd_pkg::PERIOD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // hall_code, capture_period, loop_angle, zero fill
   input  logic [hsasd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // measured_angle, direction, speed_per_period, raw_rpm, filtered_rpm,
   // angle_correction, zero fill
   output logic [hsasd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // period_error
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_wen,
   input  logic [hsasd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hsasd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [hsasd_pkg::PHASE_W-1:0] phase_ff;
   hsasd_pkg::back_cfg_type       cfg_ff;

   logic                q_ready, q_valid, q_pop, push;
   hsasd_pkg::item_type push_item, q_head;

   logic [hsasd_pkg::ANGLE_FW-1:0]       o_angle;
   logic signed [hsasd_pkg::DIR_W-1:0]   o_dir;
   logic signed [hsasd_pkg::SPEED_W-1:0] o_speed;
   logic signed [hsasd_pkg::RPM_W-1:0]   o_raw, o_filt;
   logic signed [hsasd_pkg::CORR_W-1:0]  o_corr;
   logic                                 o_perr;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hsasd_pkg::PHASE_RST;
         cfg_ff.speed_num <= hsasd_pkg::SPEED_NUM_RST;
         cfg_ff.rpm_num  <= hsasd_pkg::RPM_NUM_RST;
         cfg_ff.alpha    <= hsasd_pkg::ALPHA_RST;
         cfg_ff.corr_div <= hsasd_pkg::CDIV_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            hsasd_pkg::CSR_PHASE_OFFSET:
               phase_ff <= csr_wdata[hsasd_pkg::PHASE_W-1:0];
            hsasd_pkg::CSR_SPEED_NUMERATOR:
               cfg_ff.speed_num <= csr_wdata[hsasd_pkg::SPEED_NUM_W-1:0];
            hsasd_pkg::CSR_RPM_NUMERATOR:
               cfg_ff.rpm_num <= csr_wdata[hsasd_pkg::RPM_NUM_W-1:0];
            hsasd_pkg::CSR_FILTER_ALPHA:
               cfg_ff.alpha <= csr_wdata[hsasd_pkg::ALPHA_W-1:0];
            hsasd_pkg::CSR_CORRECTION_DIVISOR:
               cfg_ff.corr_div <= csr_wdata[hsasd_pkg::CDIV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hsasd_front #(
      .ANGLE_BITS  (ANGLE_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .op           (hsasd_pkg::op_type'(req_tuser[0])),
      .code         (req_tdata[2:0]),
      .period_field (req_tdata[18:3]),
      .loop_field   (req_tdata[34:19]),
      .phase_offset (phase_ff),
      .q_ready      (q_ready),
      .push         (push),
      .push_item    (push_item)
   );

   hsasd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   hsasd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_angle (o_angle),
      .out_dir   (o_dir),
      .out_speed (o_speed),
      .out_raw   (o_raw),
      .out_filt  (o_filt),
      .out_corr  (o_corr),
      .out_perr  (o_perr)
   );

   assign rsp_tdata = {1'b0, o_corr, o_filt, o_raw, o_speed, o_dir, o_angle};
   assign rsp_tuser = o_perr;

endmodule

// File: hw/rtl/hsasd_front.sv
`timescale 1ns / 1ps
module hsasd_front #(
   parameter int ANGLE_BITS  = hsasd_pkg::ANGLE_BITS_DEF,
   parameter int PERIOD_BITS = hsasd_pkg::PERIOD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  hsasd_pkg::op_type                    op,
   input  logic [hsasd_pkg::CODE_W-1:0]         code,
   input  logic [hsasd_pkg::PERIOD_FW-1:0]      period_field,
   input  logic [hsasd_pkg::LOOP_FW-1:0]        loop_field,
   input  logic [hsasd_pkg::PHASE_W-1:0]        phase_offset,
   input  logic                                 q_ready,
   output logic                                 push,
   output hsasd_pkg::item_type                  push_item
);

   logic [hsasd_pkg::CODE_W-1:0] prev_code_ff, prev_code_in;
   logic [ANGLE_BITS-1:0]        angle_ff, angle_in;
   logic signed [1:0]            dir_ff, dir_in;

   logic [2:0]                   idx, pidx, fwd_prev, bwd_prev;
   logic [3:0]                   n;
   logic                         take;
   logic [hsasd_pkg::ANGLE_MAX_W+1:0] asum;
   logic [hsasd_pkg::PERIOD_MAX_W-1:0] period_ext;
   logic [PERIOD_BITS-1:0]       period;
   logic [hsasd_pkg::ANGLE_MAX_W-1:0] loop_ext, angle_ext;
   logic [ANGLE_BITS-1:0]        loop_a, diff, mag;
   logic [hsasd_pkg::ANGLE_MAX_W:0] twelfths_tab [13];

   // sector angles, fixed at elaboration
   for (genvar k = 0; k < 13; k++) begin : g_twelfths
      localparam logic [hsasd_pkg::ANGLE_MAX_W:0] TW = hsasd_pkg::twelfths(4'(k), ANGLE_BITS);
      assign twelfths_tab[k] = TW;
   end

   assign in_ready = q_ready;
   assign push     = in_valid && q_ready;

   always_comb begin
      idx      = hsasd_pkg::sector_index(code);
      pidx     = hsasd_pkg::sector_index(prev_code_ff);
      fwd_prev = (idx == 3'd0) ? 3'd5 : idx - 3'd1;
      bwd_prev = (idx == 3'd5) ? 3'd0 : idx + 3'd1;
      take     = 1'b0;
      n        = 4'd0;
      dir_in   = dir_ff;
      if (op == hsasd_pkg::OP_STARTUP) begin
         take = (idx != hsasd_pkg::NO_SECTOR);
         n    = {idx, 1'b1};
      end else if (idx != hsasd_pkg::NO_SECTOR && pidx != hsasd_pkg::NO_SECTOR) begin
         if (pidx == fwd_prev) begin
            take   = 1'b1;
            n      = {idx, 1'b0};
            dir_in = 2'sd1;
         end else if (pidx == bwd_prev) begin
            take   = 1'b1;
            n      = {bwd_prev, 1'b0} + ((idx == 3'd5) ? 4'd12 : 4'd0);
            dir_in = -2'sd1;
         end
      end
      asum = {1'b0, twelfths_tab[n]}
           + (hsasd_pkg::ANGLE_MAX_W + 2)'(phase_offset);
      angle_in     = take ? asum[ANGLE_BITS-1:0] : angle_ff;
      prev_code_in = code;
   end

   // wrapped error of the new angle against the loop angle
   always_comb begin
      period_ext = hsasd_pkg::PERIOD_MAX_W'(period_field);
      period     = period_ext[PERIOD_BITS-1:0];
      loop_ext   = hsasd_pkg::ANGLE_MAX_W'(loop_field);
      loop_a     = loop_ext[ANGLE_BITS-1:0];
      diff       = angle_in - loop_a;
      mag        = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
      angle_ext  = hsasd_pkg::ANGLE_MAX_W'(angle_in);

      push_item.op          = op;
      push_item.period_zero = (period == '0);
      push_item.period      = hsasd_pkg::PERIOD_MAX_W'(period);
      push_item.dir         = dir_in;
      push_item.angle       = angle_ext[hsasd_pkg::ANGLE_FW-1:0];
      push_item.err_neg     = diff[ANGLE_BITS-1];
      push_item.err_mag     = hsasd_pkg::ANGLE_MAX_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_code_ff <= '0;
         angle_ff     <= '0;
         dir_ff       <= '0;
      end else if (push) begin
         prev_code_ff <= prev_code_in;
         angle_ff     <= angle_in;
         dir_ff       <= dir_in;
      end
   end

endmodule

// File: hw/rtl/hsasd_queue.sv
`timescale 1ns / 1ps
module hsasd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hsasd_pkg::item_type push_item,
   output logic                ready,
   input  logic                pop,
   output logic                valid,
   output hsasd_pkg::item_type head
);

   localparam int PTR_W = $clog2(hsasd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(hsasd_pkg::QUEUE_DEPTH + 1);

   hsasd_pkg::item_type slot_ff [hsasd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign ready = (cnt_ff != CNT_W'(hsasd_pkg::QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(hsasd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(hsasd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

endmodule

// File: hw/rtl/hsasd_div.sv
`timescale 1ns / 1ps
module hsasd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  hsasd_pkg::div_req_type req,
   output hsasd_pkg::div_rsp_type rsp
);

   logic                              busy_ff, done_ff;
   logic [hsasd_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [hsasd_pkg::DIV_DSR_W-1:0]   rem_ff, dsr_ff;
   logic [hsasd_pkg::DIV_DVD_W-1:0]   quo_ff;
   logic [hsasd_pkg::DIV_DSR_W:0]     trial, diff;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial = {rem_ff, quo_ff[hsasd_pkg::DIV_DVD_W-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= hsasd_pkg::DIV_CNT_W'(hsasd_pkg::DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == hsasd_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         dsr_ff <= req.divisor;
         quo_ff <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= diff[hsasd_pkg::DIV_DSR_W] ? trial[hsasd_pkg::DIV_DSR_W-1:0]
                                              : diff[hsasd_pkg::DIV_DSR_W-1:0];
         quo_ff <= {quo_ff[hsasd_pkg::DIV_DVD_W-2:0], ~diff[hsasd_pkg::DIV_DSR_W]};
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: hw/rtl/hsasd_back.sv
`timescale 1ns / 1ps
module hsasd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  hsasd_pkg::back_cfg_type             cfg,
   input  logic                                q_valid,
   input  hsasd_pkg::item_type                 q_head,
   output logic                                q_pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [hsasd_pkg::ANGLE_FW-1:0]      out_angle,
   output logic signed [hsasd_pkg::DIR_W-1:0]  out_dir,
   output logic signed [hsasd_pkg::SPEED_W-1:0] out_speed,
   output logic signed [hsasd_pkg::RPM_W-1:0]  out_raw,
   output logic signed [hsasd_pkg::RPM_W-1:0]  out_filt,
   output logic signed [hsasd_pkg::CORR_W-1:0] out_corr,
   output logic                                out_perr
);

   hsasd_pkg::back_state_type state_ff, state_in;
   hsasd_pkg::item_type       item_ff;
   hsasd_pkg::div_req_type    div_req;
   hsasd_pkg::div_rsp_type    div_rsp;

   logic signed [hsasd_pkg::SPEED_W-1:0] held_speed_ff;
   logic signed [hsasd_pkg::RPM_W-1:0]   held_rpm_ff, filt_ff;
   logic signed [hsasd_pkg::CORR_W-1:0]  corr_ff;
   logic signed [42:0]                   prod0_ff, prod1_ff;
   logic [hsasd_pkg::ALPHA_W-1:0]        a_clamp, w_old;
   logic signed [43:0]                   fsum;
   logic signed [27:0]                   fsh;
   logic [hsasd_pkg::SPEED_W-1:0]        q, spd_mag, rpm_mag, cor_mag;
   logic signed [hsasd_pkg::RPM_W-1:0]   fsat;
   logic                                 load;

   hsasd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hsasd_pkg::BK_IDLE: begin
            if (q_valid) begin
               if (q_head.op == hsasd_pkg::OP_STARTUP) begin
                  state_in = hsasd_pkg::BK_DONE;
               end else if (q_head.period_zero) begin
                  state_in = hsasd_pkg::BK_COR_GO;
               end else begin
                  state_in = hsasd_pkg::BK_SPD_GO;
               end
            end
         end
         hsasd_pkg::BK_SPD_GO:   state_in = hsasd_pkg::BK_SPD_WAIT;
         hsasd_pkg::BK_SPD_WAIT: if (div_rsp.done) state_in = hsasd_pkg::BK_RPM_GO;
         hsasd_pkg::BK_RPM_GO:   state_in = hsasd_pkg::BK_RPM_WAIT;
         hsasd_pkg::BK_RPM_WAIT: if (div_rsp.done) state_in = hsasd_pkg::BK_FLT_MUL0;
         hsasd_pkg::BK_FLT_MUL0: state_in = hsasd_pkg::BK_FLT_MUL1;
         hsasd_pkg::BK_FLT_MUL1: state_in = hsasd_pkg::BK_FLT_SUM;
         hsasd_pkg::BK_FLT_SUM:  state_in = hsasd_pkg::BK_COR_GO;
         hsasd_pkg::BK_COR_GO:   state_in = hsasd_pkg::BK_COR_WAIT;
         hsasd_pkg::BK_COR_WAIT: if (div_rsp.done) state_in = hsasd_pkg::BK_DONE;
         hsasd_pkg::BK_DONE:     if (load) state_in = hsasd_pkg::BK_IDLE;
         default:                state_in = hsasd_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop            = (state_ff == hsasd_pkg::BK_IDLE) && q_valid;
      load             = (state_ff == hsasd_pkg::BK_DONE) && (!out_valid || out_ready);
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = hsasd_pkg::DIV_DSR_W'(item_ff.period);
      unique case (state_ff)
         hsasd_pkg::BK_SPD_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = cfg.speed_num;
         end
         hsasd_pkg::BK_RPM_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = hsasd_pkg::DIV_DVD_W'(cfg.rpm_num);
         end
         hsasd_pkg::BK_COR_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {item_ff.err_mag, 16'd0};
            div_req.divisor  = hsasd_pkg::DIV_DSR_W'((cfg.corr_div == '0) ? 16'd1
                                                                          : cfg.corr_div);
         end
         default: begin
         end
      endcase
   end

   // quotient saturation and the filter arithmetic
   always_comb begin
      q       = div_rsp.quotient;
      spd_mag = (q > hsasd_pkg::SPEED_MAX) ? hsasd_pkg::SPEED_MAX : q;
      rpm_mag = (q > hsasd_pkg::RPM_MAX) ? hsasd_pkg::RPM_MAX : q;
      cor_mag = (q > hsasd_pkg::CORR_MAX) ? hsasd_pkg::CORR_MAX : q;
      a_clamp = (cfg.alpha > hsasd_pkg::ALPHA_ONE) ? hsasd_pkg::ALPHA_ONE : cfg.alpha;
      w_old   = hsasd_pkg::ALPHA_ONE - a_clamp;
      fsum    = 44'(prod0_ff) + 44'(prod1_ff) + 44'sd32768;
      fsh     = 28'(fsum >>> 16);
      if (fsh > 28'sd16777215) begin
         fsat = 25'sd16777215;
      end else if (fsh < -28'sd16777216) begin
         fsat = -25'sd16777216;
      end else begin
         fsat = fsh[hsasd_pkg::RPM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hsasd_pkg::BK_IDLE;
         held_speed_ff <= '0;
         held_rpm_ff   <= '0;
         filt_ff       <= '0;
         out_valid     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == hsasd_pkg::BK_SPD_WAIT && div_rsp.done) begin
            held_speed_ff <= (item_ff.dir == 2'sd1) ? $signed(spd_mag) :
                             (item_ff.dir == -2'sd1) ? -$signed(spd_mag) : '0;
         end
         if (state_ff == hsasd_pkg::BK_RPM_WAIT && div_rsp.done) begin
            held_rpm_ff <= (item_ff.dir == 2'sd1) ? $signed(rpm_mag[hsasd_pkg::RPM_W-1:0]) :
                           (item_ff.dir == -2'sd1) ? -$signed(rpm_mag[hsasd_pkg::RPM_W-1:0])
                                                   : '0;
         end
         if (state_ff == hsasd_pkg::BK_FLT_SUM) begin
            filt_ff <= fsat;
         end
         if (load) begin
            out_valid <= 1'b1;
         end else if (out_ready) begin
            out_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_head;
         corr_ff <= '0;
      end
      if (state_ff == hsasd_pkg::BK_FLT_MUL0) begin
         prod0_ff <= $signed({1'b0, w_old}) * filt_ff;
      end
      if (state_ff == hsasd_pkg::BK_FLT_MUL1) begin
         prod1_ff <= $signed({1'b0, a_clamp}) * held_rpm_ff;
      end
      if (state_ff == hsasd_pkg::BK_COR_WAIT && div_rsp.done) begin
         corr_ff <= item_ff.err_neg ? -$signed(cor_mag[hsasd_pkg::CORR_W-1:0])
                                    : $signed(cor_mag[hsasd_pkg::CORR_W-1:0]);
      end
      if (load) begin
         out_angle <= item_ff.angle;
         out_dir   <= item_ff.dir;
         out_perr  <= (item_ff.op == hsasd_pkg::OP_EDGE) && item_ff.period_zero;
         out_filt  <= filt_ff;
         out_corr  <= corr_ff;
         if (item_ff.op == hsasd_pkg::OP_EDGE) begin
            out_speed <= held_speed_ff;
            out_raw   <= held_rpm_ff;
         end else begin
            out_speed <= '0;
            out_raw   <= '0;
         end
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

   a_startup_zero: assert property (@(posedge clock) disable iff (reset)
      (load && item_ff.op == hsasd_pkg::OP_STARTUP) |=>
         (out_speed == '0 && out_raw == '0 && out_corr == '0 && !out_perr))
      else $error("startup result carries speed or correction");

   a_unknown_dir: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_dir == '0) |-> (out_speed == '0 && out_raw == '0))
      else $error("speed reported with unknown direction");

endmodule
